FILE: rtl/core/arm_pd_position_controller_unit_assert.svh
// assertion macros for the arm pd position controller
// used at the end of arm_pd_position_controller_unit; no other dependencies
`ifndef ARM_PD_POSITION_CONTROLLER_UNIT_ASSERT_SVH
`define ARM_PD_POSITION_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ARMPD_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ARMPD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/armpd_pkg.sv
// shared constants, codes and types for the arm pd position controller
// no dependencies; used by every other rtl file but the assert header
`default_nettype none

package armpd_pkg;

  localparam int DRIVE_FULL_SCALE_DEF = 1024;

  // field widths
  localparam int POS_W   = 13;
  localparam int RAW_W   = 12;
  localparam int STATE_W = 4;
  localparam int LSTAT_W = 2;
  localparam int GAIN_W  = 6;
  localparam int BAND_W  = 10;
  localparam int DELAY_W = 16;
  localparam int ERR_W   = 14;
  localparam int DERR_W  = 15;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_KP                = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KD                = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ARRIVAL_BAND      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNLOCK_DELAY      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GROUND_POSITION   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_FINISH_HANG       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_VOLTAGE       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_STARTING_POSITION = 3'd7;

  // register reset values
  localparam logic [GAIN_W-1:0]  KP_RST               = 6'd8;
  localparam logic [GAIN_W-1:0]  KD_RST               = 6'd1;
  localparam logic [BAND_W-1:0]  ARRIVAL_BAND_RST     = 10'd205;
  localparam logic [DELAY_W-1:0] UNLOCK_DELAY_RST     = 16'd25;
  localparam logic [POS_W-1:0]   GROUND_POSITION_RST  = 13'd0;
  localparam logic [POS_W-1:0]   FINISH_HANG_RST      = 13'd0;
  localparam logic [POS_W-1:0]   LOW_VOLTAGE_RST      = 13'd1024;
  localparam logic [POS_W-1:0]   STARTING_POSITION_RST = 13'd0;

  localparam logic [POS_W-1:0] GROUND_MARGIN = 13'd10;

  // arm position states
  localparam logic [STATE_W-1:0] ST_START    = 4'd0;
  localparam logic [STATE_W-1:0] ST_FAR      = 4'd1;
  localparam logic [STATE_W-1:0] ST_MIDDLE   = 4'd2;
  localparam logic [STATE_W-1:0] ST_NEAR     = 4'd3;
  localparam logic [STATE_W-1:0] ST_FEEDER   = 4'd4;
  localparam logic [STATE_W-1:0] ST_APPROACH = 4'd5;
  localparam logic [STATE_W-1:0] ST_HANG     = 4'd6;
  localparam logic [STATE_W-1:0] ST_GROUND   = 4'd7;
  localparam logic [STATE_W-1:0] ST_CRASH    = 4'd8;

  // lock status codes on the result channel
  localparam logic [LSTAT_W-1:0] LS_LOCKED    = 2'd0;
  localparam logic [LSTAT_W-1:0] LS_UNLOCKING = 2'd1;
  localparam logic [LSTAT_W-1:0] LS_UNLOCKED  = 2'd2;

  typedef enum logic [2:0] {
    PH_LOCKED    = 3'b001,
    PH_UNLOCKING = 3'b010,
    PH_UNLOCKED  = 3'b100
  } lock_phase_t;

  typedef enum logic [2:0] {
    SPD_FULL = 3'b001,
    SPD_MED  = 3'b010,
    SPD_LOW  = 3'b100
  } speed_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  kd;
    logic [BAND_W-1:0]  arrival_band;
    logic [DELAY_W-1:0] unlock_delay_ticks;
    logic [POS_W-1:0]   ground_position;
    logic [POS_W-1:0]   finish_hang_position;
    logic [POS_W-1:0]   low_voltage_limit;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]        pot_sample;
    logic signed [RAW_W-1:0] raw_drive;
    logic                    state_request_valid;
    logic [STATE_W-1:0]      requested_state;
    logic [POS_W-1:0]        target_position;
    logic                    lock_cmd_valid;
    logic                    lock_cmd_value;
  } in_item_t;

  // everything the drive stage needs from the state stage
  typedef struct packed {
    logic [POS_W-1:0]         setpoint;
    logic [POS_W-1:0]         pot_sample;
    logic signed [RAW_W-1:0]  raw_drive;
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    speed_t                   speed;
    logic                     unlocked;
    logic                     lock_solenoid;
    logic [STATE_W-1:0]       arm_position_state;
    logic [LSTAT_W-1:0]       lock_status;
  } mid_t;

endpackage

`default_nettype wire

FILE: rtl/core/armpd_ifs.sv
// request and result channel interfaces of the arm pd position controller
// depends on armpd_pkg for field widths
`default_nettype none

interface armpd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [armpd_pkg::POS_W-1:0]             pot_sample;
  logic signed [armpd_pkg::RAW_W-1:0]      raw_drive;
  logic                                    state_request_valid;
  logic [armpd_pkg::STATE_W-1:0]           requested_state;
  logic [armpd_pkg::POS_W-1:0]             target_position;
  logic                                    lock_cmd_valid;
  logic                                    lock_cmd_value;

  modport source (
    output valid, pot_sample, raw_drive, state_request_valid, requested_state,
           target_position, lock_cmd_valid, lock_cmd_value,
    input  ready
  );
  modport sink (
    input  valid, pot_sample, raw_drive, state_request_valid, requested_state,
           target_position, lock_cmd_valid, lock_cmd_value,
    output ready
  );
endinterface

interface armpd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [armpd_pkg::RAW_W-1:0]  motor_drive;
  logic                                lock_solenoid;
  logic [armpd_pkg::STATE_W-1:0]       arm_position_state;
  logic [armpd_pkg::LSTAT_W-1:0]       lock_status;

  modport source (
    output valid, motor_drive, lock_solenoid, arm_position_state, lock_status,
    input  ready
  );
  modport sink (
    input  valid, motor_drive, lock_solenoid, arm_position_state, lock_status,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/armpd_state.sv
// state stage: position requests, speed class, unlock sequence, error terms
// depends on armpd_pkg; holds all per-tick state of the controller
`default_nettype none

module armpd_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  armpd_pkg::in_item_t item,
  input  armpd_pkg::cfg_t     cfg,
  output armpd_pkg::mid_t     mid
);

  function automatic armpd_pkg::speed_t next_speed(
    input logic [armpd_pkg::STATE_W-1:0] cur,
    input logic [armpd_pkg::STATE_W-1:0] req,
    input armpd_pkg::speed_t             old
  );
    armpd_pkg::speed_t s;
    logic              cur_fmn;
    logic              cur_gc;
    logic              cur_start;
    s         = old;
    cur_fmn   = (cur == armpd_pkg::ST_FAR) || (cur == armpd_pkg::ST_MIDDLE) ||
                (cur == armpd_pkg::ST_NEAR);
    cur_gc    = (cur == armpd_pkg::ST_GROUND) || (cur == armpd_pkg::ST_CRASH);
    cur_start = (cur == armpd_pkg::ST_START);
    case (req)
      armpd_pkg::ST_START: s = armpd_pkg::SPD_MED;
      armpd_pkg::ST_FAR, armpd_pkg::ST_MIDDLE, armpd_pkg::ST_NEAR,
      armpd_pkg::ST_FEEDER: begin
        if (cur_start)   s = armpd_pkg::SPD_LOW;
        else if (cur_gc) s = armpd_pkg::SPD_FULL;
        else             s = armpd_pkg::SPD_MED;
      end
      armpd_pkg::ST_APPROACH: begin
        // other origins keep the current class
        if (cur_fmn || cur_start) s = armpd_pkg::SPD_MED;
        else if (cur_gc)          s = armpd_pkg::SPD_FULL;
      end
      armpd_pkg::ST_HANG: s = armpd_pkg::SPD_FULL;
      armpd_pkg::ST_GROUND, armpd_pkg::ST_CRASH: begin
        if (cur_gc || cur == armpd_pkg::ST_APPROACH || cur_start) s = armpd_pkg::SPD_FULL;
        else if (cur_fmn)                                         s = armpd_pkg::SPD_MED;
        else                                                      s = armpd_pkg::SPD_LOW;
      end
      default: s = old;
    endcase
    return s;
  endfunction

  logic [armpd_pkg::POS_W-1:0]         setpoint_r, setpoint_nxt;
  logic signed [armpd_pkg::ERR_W-1:0]  prev_err_r;
  logic [armpd_pkg::STATE_W-1:0]       current_r, current_nxt;
  logic [armpd_pkg::STATE_W-1:0]       wanted_r, wanted_nxt;
  armpd_pkg::speed_t                   speed_r, speed_nxt;
  armpd_pkg::lock_phase_t              phase_r, phase_cmd, phase_nxt;
  logic [armpd_pkg::DELAY_W-1:0]       count_r, count_cmd, count_nxt;
  logic                                sol_r, sol_nxt;

  logic                                req_ok;
  logic signed [armpd_pkg::ERR_W-1:0]  err;
  logic signed [armpd_pkg::DERR_W-1:0] derr;
  logic signed [armpd_pkg::ERR_W-1:0]  band_s;
  logic signed [armpd_pkg::ERR_W-1:0]  neg_band;
  logic                                arrived;
  logic [armpd_pkg::LSTAT_W-1:0]       lstat;

  // request: out-of-range codes are dropped whole
  assign req_ok       = item.state_request_valid && (item.requested_state <= armpd_pkg::ST_CRASH);
  assign setpoint_nxt = req_ok ? item.target_position : setpoint_r;
  assign wanted_nxt   = req_ok ? item.requested_state : wanted_r;
  assign speed_nxt    = req_ok ? next_speed(current_r, item.requested_state, speed_r) : speed_r;

  // lock command; once unlocking starts it never relocks
  assign sol_nxt = item.lock_cmd_valid ? item.lock_cmd_value : sol_r;

  always_comb begin
    phase_cmd = phase_r;
    count_cmd = count_r;
    if (item.lock_cmd_valid && item.lock_cmd_value && phase_r == armpd_pkg::PH_LOCKED) begin
      phase_cmd = armpd_pkg::PH_UNLOCKING;
      count_cmd = '0;
    end
  end

  always_comb begin
    phase_nxt = phase_cmd;
    count_nxt = count_cmd;
    if (phase_cmd == armpd_pkg::PH_UNLOCKING) begin
      if (count_cmd >= cfg.unlock_delay_ticks) begin
        phase_nxt = armpd_pkg::PH_UNLOCKED;
      end else begin
        count_nxt = count_cmd + {{(armpd_pkg::DELAY_W-1){1'b0}}, 1'b1};
      end
    end
  end

  // error terms against the updated setpoint
  assign err      = $signed({1'b0, setpoint_nxt}) - $signed({1'b0, item.pot_sample});
  assign derr     = $signed({err[armpd_pkg::ERR_W-1], err}) -
                    $signed({prev_err_r[armpd_pkg::ERR_W-1], prev_err_r});
  assign band_s   = $signed({{(armpd_pkg::ERR_W-armpd_pkg::BAND_W){1'b0}}, cfg.arrival_band});
  assign neg_band = -band_s;
  assign arrived  = (err < band_s) && (err > neg_band);

  assign current_nxt = arrived ? wanted_nxt : current_r;

  always_comb begin
    case (phase_nxt)
      armpd_pkg::PH_LOCKED:    lstat = armpd_pkg::LS_LOCKED;
      armpd_pkg::PH_UNLOCKING: lstat = armpd_pkg::LS_UNLOCKING;
      armpd_pkg::PH_UNLOCKED:  lstat = armpd_pkg::LS_UNLOCKED;
      default:                 lstat = armpd_pkg::LS_LOCKED;
    endcase
  end

  always_comb begin
    mid.setpoint           = setpoint_nxt;
    mid.pot_sample         = item.pot_sample;
    mid.raw_drive          = item.raw_drive;
    mid.err                = err;
    mid.derr               = derr;
    mid.speed              = speed_nxt;
    mid.unlocked           = (phase_nxt == armpd_pkg::PH_UNLOCKED);
    mid.lock_solenoid      = sol_nxt;
    mid.arm_position_state = current_nxt;
    mid.lock_status        = lstat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= armpd_pkg::STARTING_POSITION_RST;
      prev_err_r <= '0;
      current_r  <= armpd_pkg::ST_START;
      wanted_r   <= armpd_pkg::ST_START;
      speed_r    <= armpd_pkg::SPD_LOW;
      phase_r    <= armpd_pkg::PH_LOCKED;
      count_r    <= '0;
      sol_r      <= 1'b0;
    end else if (step) begin
      setpoint_r <= setpoint_nxt;
      prev_err_r <= err;
      current_r  <= current_nxt;
      wanted_r   <= wanted_nxt;
      speed_r    <= speed_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      sol_r      <= sol_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/armpd_drive.sv
// drive stage: pd law, speed-class clamp, inhibit rule and lock gating
// depends on armpd_pkg; purely combinational between pipeline registers
`default_nettype none

module armpd_drive #(
  parameter int FULL_SCALE = armpd_pkg::DRIVE_FULL_SCALE_DEF
) (
  input  armpd_pkg::mid_t                   mid,
  input  armpd_pkg::cfg_t                   cfg,
  output logic signed [armpd_pkg::RAW_W-1:0] motor_drive
);

  localparam int LIM_W  = $clog2(FULL_SCALE + 1) + 1;
  localparam int PROD_W = armpd_pkg::GAIN_W + 1 + armpd_pkg::DERR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = (SUM_W > LIM_W + 1) ? SUM_W : LIM_W + 1;

  localparam logic signed [CMP_W-1:0] LIM_FULL = CMP_W'(FULL_SCALE);
  localparam logic signed [CMP_W-1:0] LIM_MED  = CMP_W'((FULL_SCALE * 4) / 5);
  localparam logic signed [CMP_W-1:0] LIM_LOW  = CMP_W'(FULL_SCALE / 2);

  function automatic logic signed [CMP_W-1:0] sat(
    input logic signed [CMP_W-1:0] v,
    input logic signed [CMP_W-1:0] lim
  );
    logic signed [CMP_W-1:0] nlim;
    nlim = -lim;
    if (v > lim)       return lim;
    else if (v < nlim) return nlim;
    else               return v;
  endfunction

  logic signed [CMP_W-1:0]          kp_x, kd_x, err_x, derr_x;
  logic signed [CMP_W-1:0]          p_term, d_term, pd_sum;
  logic signed [CMP_W-1:0]          lim;
  logic signed [CMP_W-1:0]          pd_clamped, raw_clamped, result;
  logic [armpd_pkg::POS_W:0]        ground_lim;
  logic                             inhibit;

  assign kp_x   = CMP_W'($signed({1'b0, cfg.kp}));
  assign kd_x   = CMP_W'($signed({1'b0, cfg.kd}));
  assign err_x  = CMP_W'(mid.err);
  assign derr_x = CMP_W'(mid.derr);
  assign p_term = kp_x * err_x;
  assign d_term = kd_x * derr_x;
  assign pd_sum = p_term + d_term;

  always_comb begin
    case (mid.speed)
      armpd_pkg::SPD_FULL: lim = LIM_FULL;
      armpd_pkg::SPD_MED:  lim = LIM_MED;
      armpd_pkg::SPD_LOW:  lim = LIM_LOW;
      default:             lim = LIM_LOW;
    endcase
  end

  assign pd_clamped  = sat(pd_sum, lim);
  assign raw_clamped = sat(CMP_W'(mid.raw_drive), LIM_FULL);

  // manual drive takes over above ground while pushing up, except at the finish hang position, or on a low sample
  assign ground_lim = {1'b0, cfg.ground_position} + {1'b0, armpd_pkg::GROUND_MARGIN};
  assign inhibit    = (({1'b0, mid.setpoint} > ground_lim) && (pd_clamped > 0) &&
                       (mid.setpoint != cfg.finish_hang_position)) ||
                      (mid.pot_sample < cfg.low_voltage_limit);

  assign result      = !mid.unlocked ? '0 : (inhibit ? raw_clamped : pd_clamped);
  assign motor_drive = result[armpd_pkg::RAW_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/arm_pd_position_controller_unit.sv
// top level of the arm pd position controller: config registers and pipeline
// depends on armpd_pkg, armpd_ifs, armpd_state, armpd_drive and the assert header
//
// usage
// - in_ch carries one request per control tick: pot sample, manual drive,
//   an optional position request (state code and target) and an optional
//   lock command; it is taken when valid and ready are both high
// - out_ch returns exactly one result per request, in order: motor drive,
//   solenoid drive, last reached position state and lock status
// - cfg_we/cfg_addr/cfg_wdata write one gain, band, delay or limit register
//   per cycle; write only while no request is in flight
// - a result passes from the input register through the state stage
//   register to the result register, from which out_ch offers it
// - throughput: one request per cycle unless out_ch stalls; the per-tick
//   state (setpoint, last error, states, unlock counter) closes in the single state stage
// - a stalled out_ch holds its result; the stages behind it keep filling
//   until the input register is full, then in_ch.ready drops
// - reset (rst_n low, synchronous): registers return to defaults, setpoint
//   to the starting position, lock to locked, speed class low, pipe empty
`default_nettype none

module arm_pd_position_controller_unit #(
  parameter int DRIVE_FULL_SCALE = armpd_pkg::DRIVE_FULL_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  armpd_in_if.sink                            in_ch,
  armpd_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [armpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [armpd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration registers
  armpd_pkg::cfg_t cfg_r;

  // pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic mid_valid_r, mid_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_load;     // result register may take a new result
  logic mid_accept;   // state stage register may take a new request
  logic in_ready;
  logic step;         // request in the input register moves on this cycle

  armpd_pkg::in_item_t              s1_item_r;
  armpd_pkg::in_item_t              in_item;
  armpd_pkg::mid_t                  mid;
  armpd_pkg::mid_t                  mid_r;
  logic signed [armpd_pkg::RAW_W-1:0] drive;

  logic signed [armpd_pkg::RAW_W-1:0] out_drive_r;
  logic                               out_sol_r;
  logic [armpd_pkg::STATE_W-1:0]      out_state_r;
  logic [armpd_pkg::LSTAT_W-1:0]      out_lstat_r;

  // no starting position register is kept: reset loads a fixed value,
  // so a write to that address changes nothing observable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp                   <= armpd_pkg::KP_RST;
      cfg_r.kd                   <= armpd_pkg::KD_RST;
      cfg_r.arrival_band         <= armpd_pkg::ARRIVAL_BAND_RST;
      cfg_r.unlock_delay_ticks   <= armpd_pkg::UNLOCK_DELAY_RST;
      cfg_r.ground_position      <= armpd_pkg::GROUND_POSITION_RST;
      cfg_r.finish_hang_position <= armpd_pkg::FINISH_HANG_RST;
      cfg_r.low_voltage_limit    <= armpd_pkg::LOW_VOLTAGE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        armpd_pkg::CFG_KP:           cfg_r.kp <= cfg_wdata[armpd_pkg::GAIN_W-1:0];
        armpd_pkg::CFG_KD:           cfg_r.kd <= cfg_wdata[armpd_pkg::GAIN_W-1:0];
        armpd_pkg::CFG_ARRIVAL_BAND:
          cfg_r.arrival_band <= cfg_wdata[armpd_pkg::BAND_W-1:0];
        armpd_pkg::CFG_UNLOCK_DELAY:
          cfg_r.unlock_delay_ticks <= cfg_wdata[armpd_pkg::DELAY_W-1:0];
        armpd_pkg::CFG_GROUND_POSITION:
          cfg_r.ground_position <= cfg_wdata[armpd_pkg::POS_W-1:0];
        armpd_pkg::CFG_FINISH_HANG:
          cfg_r.finish_hang_position <= cfg_wdata[armpd_pkg::POS_W-1:0];
        armpd_pkg::CFG_LOW_VOLTAGE:
          cfg_r.low_voltage_limit <= cfg_wdata[armpd_pkg::POS_W-1:0];
        armpd_pkg::CFG_STARTING_POSITION: begin
          cfg_r <= cfg_r;
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // each stage fills whenever it is empty or the stage after it moves
  assign out_load   = !out_valid_r || out_ch.ready;
  assign mid_accept = !mid_valid_r || out_load;
  assign in_ready   = !s1_valid_r || mid_accept;
  assign step       = s1_valid_r && mid_accept;

  assign s1_valid_nxt  = in_ready   ? in_ch.valid : s1_valid_r;
  assign mid_valid_nxt = mid_accept ? s1_valid_r  : mid_valid_r;
  assign out_valid_nxt = out_load   ? mid_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      mid_valid_r <= mid_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    in_item.pot_sample          = in_ch.pot_sample;
    in_item.raw_drive           = in_ch.raw_drive;
    in_item.state_request_valid = in_ch.state_request_valid;
    in_item.requested_state     = in_ch.requested_state;
    in_item.target_position     = in_ch.target_position;
    in_item.lock_cmd_valid      = in_ch.lock_cmd_valid;
    in_item.lock_cmd_value      = in_ch.lock_cmd_value;
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_item_r <= in_item;
    end
  end

  // state stage: requests, lock sequence, error and derivative
  armpd_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .mid   (mid)
  );

  always_ff @(posedge clk) begin
    if (step) begin
      mid_r <= mid;
    end
  end

  // drive stage: pd law, clamp, inhibit and lock gating
  armpd_drive #(
    .FULL_SCALE (DRIVE_FULL_SCALE)
  ) u_drive (
    .mid         (mid_r),
    .cfg         (cfg_r),
    .motor_drive (drive)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_load && mid_valid_r) begin
      out_drive_r <= drive;
      out_sol_r   <= mid_r.lock_solenoid;
      out_state_r <= mid_r.arm_position_state;
      out_lstat_r <= mid_r.lock_status;
    end
  end

  assign in_ch.ready               = in_ready;
  assign out_ch.valid              = out_valid_r;
  assign out_ch.motor_drive        = out_drive_r;
  assign out_ch.lock_solenoid      = out_sol_r;
  assign out_ch.arm_position_state = out_state_r;
  assign out_ch.lock_status        = out_lstat_r;

`include "arm_pd_position_controller_unit_assert.svh"

  // a locked or unlocking arm never reports a nonzero drive
  `ARMPD_ASSERT_IMP(a_drive_gated, clk, rst_n,
    out_valid_r && (out_lstat_r != armpd_pkg::LS_UNLOCKED), out_drive_r == '0,
    "motor drive nonzero while not unlocked")

  // a request in the input register is never dropped while the pipe stalls
  `ARMPD_ASSERT_NXT(a_s1_kept, clk, rst_n, s1_valid_r && !mid_accept, s1_valid_r,
    "request lost from input register")

  // the state stage result is never dropped while the result register is full
  `ARMPD_ASSERT_NXT(a_mid_kept, clk, rst_n, mid_valid_r && !out_load, mid_valid_r,
    "request lost from state stage register")

endmodule

`default_nettype wire
